@@ sv/msptmr_pkg.sv @@
package msptmr_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int SLOT_AW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int TICK_W     = 32;
  localparam int IVL_W      = 16;
  localparam int DUR_W      = 16;
  localparam int CALLS_W    = 17;
  localparam int DIV_CNT_W  = $clog2(TICK_W);

  typedef enum logic [2:0] {
    KIND_FIRE      = 3'd0,
    KIND_TICK_DONE = 3'd1,
    KIND_ADDED     = 3'd2,
    KIND_FULL      = 3'd3,
    KIND_REJECTED  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RESP,
    ST_DIV,
    ST_ADD,
    ST_RD,
    ST_EVAL,
    ST_DONE
  } state_t;

  // one slot entry; rem tracks tick_count modulo interval
  typedef struct packed {
    logic [IVL_W-1:0]   interval;
    logic [DUR_W-1:0]   duration;
    logic [CALLS_W-1:0] calls;
    logic [IVL_W-1:0]   rem;
  } slot_entry_t;

  typedef struct packed {
    logic               we;
    logic [SLOT_AW-1:0] addr;
    slot_entry_t        data;
  } ram_wr_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

  // low four bits of a slot number
  function automatic logic [3:0] slot_field(input logic [SLOT_AW-1:0] s);
    logic [SLOT_AW+3:0] ext;
    ext = {4'b0000, s};
    return ext[3:0];
  endfunction

endpackage

@@ sv/msptmr_slot_ram.sv @@
module msptmr_slot_ram (
  input  logic                          clk,
  input  msptmr_pkg::ram_wr_t           wr,
  input  logic                          rd_en,
  input  logic [msptmr_pkg::SLOT_AW-1:0] rd_addr,
  output msptmr_pkg::slot_entry_t       rd_data
);
  import msptmr_pkg::*;

  slot_entry_t mem [SLOT_COUNT];
  slot_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/msptmr_mod_unit.sv @@
module msptmr_mod_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [msptmr_pkg::TICK_W-1:0] dividend,
  input  logic [msptmr_pkg::IVL_W-1:0]  divisor,
  output msptmr_pkg::mod_stat_t         stat,
  output logic [msptmr_pkg::IVL_W-1:0]  rem
);
  import msptmr_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [TICK_W-1:0]    dvd_r, dvd_nxt;
  logic [IVL_W-1:0]     dvs_r, dvs_nxt;
  logic [IVL_W-1:0]     rem_r, rem_nxt;
  logic [IVL_W:0]       trial;
  logic [IVL_W:0]       diff;

  // restoring remainder, one dividend bit per cycle, msb first
  always_comb begin
    trial    = {rem_r, dvd_r[TICK_W-1]};
    diff     = trial - {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = (trial >= {1'b0, dvs_r}) ? diff[IVL_W-1:0] : trial[IVL_W-1:0];
      dvd_nxt = {dvd_r[TICK_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(TICK_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign rem       = rem_r;

endmodule

@@ sv/multi_slot_periodic_timer.sv @@
// channel | direction | ports                             | handshake
// in      | input     | in_op, in_interval, in_duration   | in_valid / in_stall
// out     | output    | out_kind, out_slot, out_last      | out_valid / out_stall
//
// one request at a time; a tick reads each valid slot from the ram and skips free
// slots without a read, then gives tick done; an add runs the bit-serial modulo unit
// that seeds the per-slot remainder; rejected and full adds go straight to a response
// synchronous active-low reset clears the tick counter, valid bits, sequencer
// and output valid flag; the slot ram is not cleared
// out_stall holds the walk at the next result; a request is taken only while idle
module multi_slot_periodic_timer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [15:0] in_interval,
  input  logic [15:0] in_duration,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [3:0]  out_slot,
  output logic        out_last
);
  import msptmr_pkg::*;

  localparam logic [SLOT_AW-1:0] LAST_SLOT = SLOT_AW'(SLOT_COUNT - 1);

  // sequencer and slot bookkeeping
  state_t                  state_r, state_nxt;
  logic [SLOT_AW-1:0]      idx_r, idx_nxt;
  logic [SLOT_AW-1:0]      alloc_r, alloc_nxt;
  kind_t                   resp_kind_r, resp_kind_nxt;
  logic [TICK_W-1:0]       tick_r, tick_nxt;
  logic [SLOT_COUNT-1:0]   valid_r, valid_nxt;
  logic [IVL_W-1:0]        ivl_r;
  logic [DUR_W-1:0]        dur_r;

  // output register
  logic                    out_valid_r;
  kind_t                   out_kind_r;
  logic [3:0]              out_slot_r;
  logic                    out_last_r;

  logic                    in_acc;
  logic                    out_free;
  logic                    emit;
  kind_t                   emit_kind;
  logic [3:0]              emit_slot;
  logic                    emit_last;

  // lowest free slot
  logic                    free_found;
  logic [SLOT_AW-1:0]      free_idx;

  // slot ram and modulo unit
  ram_wr_t                 ram_wr;
  logic                    ram_rd_en;
  slot_entry_t             ram_rd;
  logic                    mod_start;
  mod_stat_t               mod_stat;
  logic [IVL_W-1:0]        mod_rem;

  // per-slot update during the tick walk
  logic [CALLS_W-1:0]      calls_inc;
  logic                    expire;
  logic                    fire;
  logic [IVL_W:0]          rem_inc;
  logic [IVL_W-1:0]        rem_next;
  slot_entry_t             upd;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  msptmr_slot_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd_en   (ram_rd_en),
    .rd_addr (idx_r),
    .rd_data (ram_rd)
  );

  // remainder of the current tick count, taken once per add
  msptmr_mod_unit u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (tick_r),
    .divisor  (ivl_r),
    .stat     (mod_stat),
    .rem      (mod_rem)
  );

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_AW'(i);
      end
    end
  end

  // slot update: calls counts ticks while a duration is set, rem walks tick_count modulo interval
  always_comb begin
    calls_inc = ram_rd.calls + 1'b1;
    expire    = (ram_rd.duration != '0) && (calls_inc > {1'b0, ram_rd.duration});
    fire      = !expire && (ram_rd.rem == '0);
    rem_inc   = {1'b0, ram_rd.rem} + 1'b1;
    // the counter wrap restarts every remainder at zero
    if ((&tick_r) || (rem_inc == {1'b0, ram_rd.interval})) begin
      rem_next = '0;
    end else begin
      rem_next = rem_inc[IVL_W-1:0];
    end
    upd          = ram_rd;
    upd.calls    = (ram_rd.duration != '0) ? calls_inc : ram_rd.calls;
    upd.rem      = rem_next;
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    alloc_nxt     = alloc_r;
    resp_kind_nxt = resp_kind_r;
    tick_nxt      = tick_r;
    valid_nxt     = valid_r;
    emit          = 1'b0;
    emit_kind     = KIND_TICK_DONE;
    emit_slot     = '0;
    emit_last     = 1'b1;
    ram_wr        = '0;
    ram_rd_en     = 1'b0;
    mod_start     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_op) begin
            if (in_interval == '0) begin
              resp_kind_nxt = KIND_REJECTED;
              state_nxt     = ST_RESP;
            end else if (!free_found) begin
              resp_kind_nxt = KIND_FULL;
              state_nxt     = ST_RESP;
            end else begin
              alloc_nxt = free_idx;
              state_nxt = ST_DIV;
            end
          end else begin
            idx_nxt   = '0;
            state_nxt = ST_RD;
          end
        end
      end
      ST_RESP: begin
        emit      = 1'b1;
        emit_kind = resp_kind_r;
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        // first cycle here starts the unit, ivl_r is loaded by then
        if (!mod_stat.busy && !mod_stat.done) begin
          mod_start = 1'b1;
        end
        if (mod_stat.done) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        emit      = 1'b1;
        emit_kind = KIND_ADDED;
        emit_slot = slot_field(alloc_r);
        if (out_free) begin
          ram_wr.we            = 1'b1;
          ram_wr.addr          = alloc_r;
          ram_wr.data.interval = ivl_r;
          ram_wr.data.duration = dur_r;
          ram_wr.data.calls    = '0;
          ram_wr.data.rem      = mod_rem;
          valid_nxt[alloc_r]   = 1'b1;
          state_nxt            = ST_IDLE;
        end
      end
      ST_RD: begin
        // free slots are skipped without a ram read
        if (valid_r[idx_r]) begin
          ram_rd_en = 1'b1;
          state_nxt = ST_EVAL;
        end else if (idx_r == LAST_SLOT) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_EVAL: begin
        emit      = fire;
        emit_kind = KIND_FIRE;
        emit_slot = slot_field(idx_r);
        emit_last = 1'b0;
        if (!fire || out_free) begin
          if (expire) begin
            valid_nxt[idx_r] = 1'b0;
          end else begin
            ram_wr.we   = 1'b1;
            ram_wr.addr = idx_r;
            ram_wr.data = upd;
          end
          if (idx_r == LAST_SLOT) begin
            state_nxt = ST_DONE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_RD;
          end
        end
      end
      ST_DONE: begin
        emit      = 1'b1;
        emit_kind = KIND_TICK_DONE;
        if (out_free) begin
          tick_nxt  = tick_r + 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      alloc_r     <= '0;
      resp_kind_r <= KIND_TICK_DONE;
      tick_r      <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      alloc_r     <= alloc_nxt;
      resp_kind_r <= resp_kind_nxt;
      tick_r      <= tick_nxt;
      valid_r     <= valid_nxt;
      if (emit && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request payload and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ivl_r <= in_interval;
      dur_r <= in_duration;
    end
    if (emit && out_free) begin
      out_kind_r <= emit_kind;
      out_slot_r <= emit_slot;
      out_last_r <= emit_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_slot  = out_slot_r;
  assign out_last  = out_last_r;

`ifndef SYNTHESIS
  // the tick counter moves only together with the tick done result
  assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (tick_r != $past(tick_r))) |->
      (out_valid_r && (out_kind_r == KIND_TICK_DONE)))
    else $error("tick counter advanced without tick done");

  // a slot is taken only together with its added result
  assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && ((valid_r & ~$past(valid_r)) != '0)) |->
      (out_valid_r && (out_kind_r == KIND_ADDED) &&
       ($countones(valid_r & ~$past(valid_r)) == 1)))
    else $error("slot allocated without added result");

  // only fire results leave the request open
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_last_r == (out_kind_r != KIND_FIRE)))
    else $error("last flag does not match result kind");

  // the modulo unit runs only for an add in progress
  assert property (@(posedge clk) disable iff (!rst_n)
    mod_stat.busy |-> (state_r == ST_DIV))
    else $error("modulo unit busy outside add");
`endif

endmodule
